// ===== src/zrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrs_pkg
// shared types and constants for the zone relay sequencer
// ----------------------------------------------------------------------------
package zrs_pkg;

    localparam int ZONES = 4;
    localparam int ZW    = 2;
    localparam int TW    = 24;

    localparam logic [TW-1:0] TIMER_MAX   = 24'hFFFFFF;
    localparam logic [TW-1:0] MS_PER_MIN  = 24'd60000;
    localparam logic [TW-1:0] HALF_MIN_MS = 24'd30000;
    localparam logic [7:0]    MIN_SAT     = 8'd255;
    localparam logic [6:0]    PCT_FULL    = 7'd100;

    // command codes
    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_GEN    = 3'd1;
    localparam logic [2:0] FN_CUSTOM = 3'd2;
    localparam logic [2:0] FN_TEST   = 3'd3;
    localparam logic [2:0] FN_STOP   = 3'd4;

    // register indexes
    localparam logic [2:0] RG_ENABLE  = 3'd0;
    localparam logic [2:0] RG_MINUTES = 3'd1;
    localparam logic [2:0] RG_WAIT    = 3'd2;
    localparam logic [2:0] RG_DEAD    = 3'd3;
    localparam logic [2:0] RG_TEST    = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input transaction
        logic exec;     // apply command / tick step
        logic div_start;
        logic div_step;
        logic finish;   // write progress, end a finished zone
    } zrs_cmd_t;

    typedef struct packed {
        logic need_div; // tick in on period with nonzero duration
        logic div_done;
    } zrs_sts_t;

endpackage

// ===== src/zrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrs_ctrl
// transaction controller: capture, execute, divide, finish, present
// ----------------------------------------------------------------------------
module zrs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            out_stall,
    output logic            out_valid,
    output zrs_pkg::zrs_cmd_t cmd,
    input  zrs_pkg::zrs_sts_t sts
);
    import zrs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_OUT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> in_stall) else $error("accept while dividing");
    a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !cmd.exec) else $error("double execute");
`endif

endmodule

// ===== src/zrs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrs_datapath
// sequencing state, registers, restoring percent divider and result
// ----------------------------------------------------------------------------
module zrs_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  zrs_pkg::zrs_cmd_t cmd,
    output zrs_pkg::zrs_sts_t sts,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    input  logic [2:0]        func,
    input  logic [3:0]        zone_mask,
    input  logic [7:0]        custom_minutes,
    input  logic signed [2:0] test_zone,
    output logic [3:0]        relay_mask,
    output logic              active,
    output logic              waiting,
    output logic [1:0]        zone,
    output logic [6:0]        progress_pct,
    output logic              cycle_done,
    output logic              any_run,
    output logic [7:0]        minutes_zone0,
    output logic [7:0]        minutes_zone1,
    output logic [7:0]        minutes_zone2,
    output logic [7:0]        minutes_zone3
);
    import zrs_pkg::*;

    localparam int DW = TW + 7; // dividend width: timer times 100

    // configuration registers
    logic [3:0]    en_reg;
    logic [31:0]   mins_reg;
    logic [TW-1:0] wait_reg, dead_reg;
    logic [11:0]   test_reg;
    logic [2:0]    ridx;

    assign ridx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= '0;
            mins_reg <= '0;
            wait_reg <= 24'd10000;
            dead_reg <= 24'd500;
            test_reg <= 12'd10;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                RG_ENABLE:  en_reg   <= pwdata[3:0];
                RG_MINUTES: mins_reg <= pwdata;
                RG_WAIT:    wait_reg <= pwdata[TW-1:0];
                RG_DEAD:    dead_reg <= pwdata[TW-1:0];
                RG_TEST:    test_reg <= pwdata[11:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            RG_ENABLE:  prdata = {28'd0, en_reg};
            RG_MINUTES: prdata = mins_reg;
            RG_WAIT:    prdata = {8'd0, wait_reg};
            RG_DEAD:    prdata = {8'd0, dead_reg};
            RG_TEST:    prdata = {20'd0, test_reg};
            default:    prdata = '0;
        endcase
    end

    // captured transaction
    logic [2:0] fn_reg;
    logic [3:0] zm_reg;
    logic [7:0] cm_reg;
    logic [2:0] tz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fn_reg <= func;
            zm_reg <= zone_mask;
            cm_reg <= custom_minutes;
            tz_reg <= test_zone;
        end
    end

    // sequencing state
    logic [ZW-1:0] qz_reg [ZONES];
    logic [TW-1:0] qd_reg [ZONES];
    logic [2:0]    qlen_reg, qpos_reg;
    logic          run_reg, wait_st_reg, dead_st_reg, test_run_reg;
    logic [ZW-1:0] cz_reg;
    logic [TW-1:0] cdur_reg, tmr_reg;
    logic [6:0]    prog_reg;
    logic [7:0]    zmin_reg [ZONES];
    logic          done_reg;
    logic [7:0]    rep_reg [ZONES];

    // divider
    logic [DW-1:0] rem_reg, quo_reg;
    logic [4:0]    cnt_reg;

    // launch candidates
    logic [3:0]    sel;
    logic [TW-1:0] ldur [ZONES];
    logic          is_start;
    logic [TW-1:0] test_ms;
    logic [TW-1:0] tinc;
    logic [TW-1:0] m_min;
    logic [7:0]    stop_min;
    logic [TW:0]   stop_sum;
    logic [7:0]    done_min;

    assign test_ms  = TW'(test_reg) * TW'(1000);
    assign tinc     = (tmr_reg < TIMER_MAX) ? tmr_reg + 1'b1 : tmr_reg;
    assign stop_sum = {1'b0, tmr_reg} + {1'b0, HALF_MIN_MS};

    // minutes for a stop in the on period, quotient of a narrow value
    always_comb
    begin
        if (tmr_reg < HALF_MIN_MS)
            stop_min = 8'd0;
        else if (stop_sum / (TW+1)'(MS_PER_MIN) > (TW+1)'(MIN_SAT))
            stop_min = MIN_SAT;
        else
            stop_min = 8'(stop_sum / (TW+1)'(MS_PER_MIN));
    end

    always_comb
    begin
        m_min = cdur_reg / MS_PER_MIN;
        if (m_min == '0)
            done_min = 8'd1;
        else if (m_min > TW'(MIN_SAT))
            done_min = MIN_SAT;
        else
            done_min = m_min[7:0];
    end

    always_comb
    begin
        is_start = 1'b0;
        sel      = '0;
        for (int i = 0; i < ZONES; i++)
            ldur[i] = '0;
        unique case (fn_reg)
            FN_GEN:
            begin
                is_start = 1'b1;
                for (int i = 0; i < ZONES; i++)
                begin
                    ldur[i] = TW'(mins_reg[8*i +: 8]) * MS_PER_MIN;
                    sel[i]  = en_reg[i] && (mins_reg[8*i +: 8] != 8'd0);
                end
            end
            FN_CUSTOM:
            begin
                is_start = (cm_reg != 8'd0);
                for (int i = 0; i < ZONES; i++)
                begin
                    ldur[i] = TW'(cm_reg) * MS_PER_MIN;
                    sel[i]  = zm_reg[i];
                end
            end
            FN_TEST:
            begin
                is_start = (test_reg != 12'd0);
                for (int i = 0; i < ZONES; i++)
                begin
                    ldur[i] = test_ms;
                    sel[i]  = tz_reg[2] || (tz_reg == 3'(i));
                end
            end
            default: ;
        endcase
    end

    assign sts.need_div = (fn_reg == FN_TICK) && run_reg && !wait_st_reg
                          && !dead_st_reg && (cdur_reg != '0);
    assign sts.div_done = (cnt_reg == 5'd0);

    // main sequencing update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg     <= '0;
            qpos_reg     <= '0;
            run_reg      <= 1'b0;
            wait_st_reg  <= 1'b0;
            dead_st_reg  <= 1'b0;
            test_run_reg <= 1'b0;
            cz_reg       <= '0;
            cdur_reg     <= '0;
            tmr_reg      <= '0;
            prog_reg     <= '0;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            for (int i = 0; i < ZONES; i++)
            begin
                zmin_reg[i] <= '0;
                rep_reg[i]  <= '0;
            end
        end
        else if (cmd.exec)
        begin
            done_reg <= 1'b0;
            for (int i = 0; i < ZONES; i++)
                rep_reg[i] <= '0;
            if (fn_reg == FN_TICK)
            begin
                if (run_reg)
                begin
                    tmr_reg <= tinc;
                    if (wait_st_reg)
                    begin
                        if (tinc >= wait_reg)
                        begin
                            cz_reg      <= qz_reg[qpos_reg[ZW-1:0]];
                            cdur_reg    <= qd_reg[qpos_reg[ZW-1:0]];
                            dead_st_reg <= 1'b1;
                            wait_st_reg <= 1'b0;
                            tmr_reg     <= '0;
                            prog_reg    <= '0;
                        end
                    end
                    else if (dead_st_reg)
                    begin
                        if (tinc >= dead_reg)
                        begin
                            dead_st_reg <= 1'b0;
                            tmr_reg     <= '0;
                            prog_reg    <= '0;
                        end
                    end
                    else
                    begin
                        // start percent divide: tinc*100 / cdur
                        rem_reg <= '0;
                        quo_reg <= DW'(tinc) * DW'(PCT_FULL);
                        cnt_reg <= 5'(DW);
                    end
                end
            end
            else if (is_start || fn_reg == FN_STOP)
            begin
                // stop any running cycle
                if (run_reg)
                begin
                    done_reg <= 1'b1;
                    for (int i = 0; i < ZONES; i++)
                        rep_reg[i] <= zmin_reg[i];
                    if (!wait_st_reg && !dead_st_reg && !test_run_reg)
                        rep_reg[cz_reg] <= stop_min;
                end
                run_reg     <= 1'b0;
                wait_st_reg <= 1'b0;
                dead_st_reg <= 1'b0;
                prog_reg    <= '0;
                qlen_reg    <= '0;
                qpos_reg    <= '0;
                if (is_start && sel != '0)
                begin
                    test_run_reg <= (fn_reg == FN_TEST);
                    for (int i = 0; i < ZONES; i++)
                        zmin_reg[i] <= '0;
                    qlen_reg    <= 3'($countones(sel));
                    run_reg     <= 1'b1;
                    dead_st_reg <= 1'b1;
                    tmr_reg     <= '0;
                    for (int i = 0; i < ZONES; i++)
                    begin
                        if (sel[i] && (sel & ((4'd1 << i) - 4'd1)) == '0)
                        begin
                            cz_reg   <= ZW'(i);
                            cdur_reg <= ldur[i];
                        end
                    end
                end
                else if (run_reg && !wait_st_reg && !dead_st_reg && !test_run_reg)
                    zmin_reg[cz_reg] <= stop_min;
            end
        end
        else if (cmd.div_step)
        begin
            if (cnt_reg != 5'd0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if ({rem_reg[DW-2:0], quo_reg[DW-1]} >= DW'(cdur_reg))
                begin
                    rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]} - DW'(cdur_reg);
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
        end
        else if (cmd.finish)
        begin
            prog_reg <= (quo_reg > DW'(PCT_FULL)) ? PCT_FULL : quo_reg[6:0];
            if (tmr_reg >= cdur_reg)
            begin
                if (!test_run_reg)
                    zmin_reg[cz_reg] <= done_min;
                qpos_reg <= qpos_reg + 1'b1;
                if (qpos_reg + 1'b1 < qlen_reg)
                begin
                    wait_st_reg <= 1'b1;
                    tmr_reg     <= '0;
                end
                else
                begin
                    run_reg  <= 1'b0;
                    qlen_reg <= '0;
                    prog_reg <= '0;
                    done_reg <= 1'b1;
                    for (int i = 0; i < ZONES; i++)
                        rep_reg[i] <= zmin_reg[i];
                    if (!test_run_reg)
                        rep_reg[cz_reg] <= done_min;
                end
            end
        end
    end

    // queue store, written on a launch
    always_ff @(posedge clk)
    begin
        if (cmd.exec && fn_reg != FN_TICK && is_start)
        begin
            for (int i = 0; i < ZONES; i++)
            begin
                if (sel[i])
                begin
                    qz_reg[$countones(sel & ((4'd1 << i) - 4'd1))] <= ZW'(i);
                    qd_reg[$countones(sel & ((4'd1 << i) - 4'd1))] <= ldur[i];
                end
            end
        end
    end

    // result fields
    assign relay_mask   = (run_reg && !wait_st_reg && !dead_st_reg) ? 4'd1 << cz_reg : 4'd0;
    assign active       = run_reg;
    assign waiting      = run_reg && wait_st_reg;
    assign zone         = run_reg ? cz_reg : '0;
    assign progress_pct = run_reg ? prog_reg : '0;
    assign cycle_done   = done_reg;
    assign minutes_zone0 = rep_reg[0];
    assign minutes_zone1 = rep_reg[1];
    assign minutes_zone2 = rep_reg[2];
    assign minutes_zone3 = rep_reg[3];
    assign any_run = (rep_reg[0] | rep_reg[1] | rep_reg[2] | rep_reg[3]) != 8'd0;

`ifndef SYNTH
    a_relay_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(relay_mask)) else $error("more than one relay on");
    a_wait_dead: assert property (@(posedge clk) disable iff (!rst_n)
        !(wait_st_reg && dead_st_reg)) else $error("wait and dead time together");
    a_pos_len: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> qpos_reg < qlen_reg) else $error("queue position overrun");
`endif

endmodule

// ===== src/zone_relay_sequencer.sv =====
`timescale 1ns / 1ps
// a command goes from accept through capture and execute to the result; a tick in the
// on period also runs the 31-step restoring percent divider and a finish step
// throughput: one transaction at a time, a new one accepted after the result
// is taken; reset clears all control state and loads register defaults
// ----------------------------------------------------------------------------
// zone_relay_sequencer
// top level: controller and datapath of the relay zone sequencer
// ----------------------------------------------------------------------------
module zone_relay_sequencer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        func,
    input  logic [3:0]        zone_mask,
    input  logic [7:0]        custom_minutes,
    input  logic signed [2:0] test_zone,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [3:0]        relay_mask,
    output logic              active,
    output logic              waiting,
    output logic [1:0]        zone,
    output logic [6:0]        progress_pct,
    output logic              cycle_done,
    output logic              any_run,
    output logic [7:0]        minutes_zone0,
    output logic [7:0]        minutes_zone1,
    output logic [7:0]        minutes_zone2,
    output logic [7:0]        minutes_zone3
);
    import zrs_pkg::*;

    zrs_cmd_t cmd;
    zrs_sts_t sts;

    assign pready = 1'b1;

    // transaction controller
    zrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath
    zrs_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .func           (func),
        .zone_mask      (zone_mask),
        .custom_minutes (custom_minutes),
        .test_zone      (test_zone),
        .relay_mask     (relay_mask),
        .active         (active),
        .waiting        (waiting),
        .zone           (zone),
        .progress_pct   (progress_pct),
        .cycle_done     (cycle_done),
        .any_run        (any_run),
        .minutes_zone0  (minutes_zone0),
        .minutes_zone1  (minutes_zone1),
        .minutes_zone2  (minutes_zone2),
        .minutes_zone3  (minutes_zone3)
    );

endmodule

// ===== verif/zone_relay_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zone_relay_sequencer_tb
// self-checking bench: an in-bench model of the zone sequencer predicts the
// status transaction for every accepted tick or command; directed tests cover
// commands, register extremes, zone completion and half-minute rounding, then
// a long random run with random idling on both channels
// ----------------------------------------------------------------------------
module zone_relay_sequencer_tb;

    import zrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int FN_CODES       = 8;
    localparam logic [2:0] TZ_ALL = 3'b111;

    typedef struct {
        logic [3:0] relay;
        logic       act;
        logic       wt;
        logic [1:0] zn;
        logic [6:0] pct;
        logic       done;
        logic       any;
        logic [7:0] mins [4];
    } status_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [2:0]        func;
    logic [3:0]        zone_mask;
    logic [7:0]        custom_minutes;
    logic signed [2:0] test_zone;
    logic              out_valid;
    logic              out_stall;
    logic [3:0]        relay_mask;
    logic              active;
    logic              waiting;
    logic [1:0]        zone;
    logic [6:0]        progress_pct;
    logic              cycle_done;
    logic              any_run;
    logic [7:0]        minutes_zone0;
    logic [7:0]        minutes_zone1;
    logic [7:0]        minutes_zone2;
    logic [7:0]        minutes_zone3;

    zone_relay_sequencer dut (.*);

    // register shadow
    logic [3:0]  cfg_enable;
    logic [31:0] cfg_minutes;
    logic [23:0] cfg_wait;
    logic [23:0] cfg_dead;
    logic [11:0] cfg_test;

    // sequencer model state
    logic [1:0]  zq_zone [4];
    int unsigned zq_dur [4];
    int          qlen;
    int          qpos;
    bit          run;
    bit          in_wait;
    bit          in_dead;
    bit          test_cycle;
    logic [1:0]  cur_zone;
    int unsigned cur_dur;
    int unsigned timer_ms;
    int unsigned pct;
    logic [7:0]  run_minutes [4];

    status_t status_q [$];
    int      errors;
    bit      idle_on;
    int      hold_asked;
    int      hold_seen;
    int      hold_left;
    int      watchdog;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // model: load the zone at the current queue position
    function automatic void begin_zone();
        cur_zone = zq_zone[qpos & 3];
        cur_dur  = zq_dur[qpos & 3];
        in_dead  = 1'b1;
        in_wait  = 1'b0;
        timer_ms = 0;
        pct      = 0;
    endfunction

    // model: end a running cycle, recording a partial on period
    function automatic bit halt_cycle();
        bit          ended;
        int unsigned r;
        logic [7:0]  ran;
        ended = 1'b0;
        if (run)
        begin
            if (!in_wait && !in_dead)
            begin
                ran = 8'd0;
                if (timer_ms >= HALF_MIN_MS)
                begin
                    r   = (timer_ms + HALF_MIN_MS) / MS_PER_MIN;
                    ran = (r > MIN_SAT) ? MIN_SAT : r[7:0];
                end
                if (!test_cycle)
                    run_minutes[cur_zone] = ran;
            end
            run     = 1'b0;
            in_wait = 1'b0;
            in_dead = 1'b0;
            pct     = 0;
            ended   = 1'b1;
        end
        qlen = 0;
        qpos = 0;
        return ended;
    endfunction

    // model: queue the selected zones and start the first
    function automatic void launch(input bit sel [4], input int unsigned dur [4],
                                   input bit is_test);
        qlen = 0;
        for (int i = 0; i < ZONES; i++)
        begin
            if (sel[i])
            begin
                zq_zone[qlen & 3] = i[1:0];
                zq_dur[qlen & 3]  = dur[i];
                qlen++;
            end
        end
        if (qlen != 0)
        begin
            test_cycle = is_test;
            for (int i = 0; i < 4; i++)
                run_minutes[i] = 8'd0;
            qpos = 0;
            run  = 1'b1;
            begin_zone();
        end
    endfunction

    // model: one millisecond tick
    function automatic bit tick_step();
        int unsigned r;
        longint unsigned q;
        if (!run)
            return 1'b0;
        if (timer_ms < TIMER_MAX)
            timer_ms++;
        if (in_wait)
        begin
            if (timer_ms >= cfg_wait)
                begin_zone();
            return 1'b0;
        end
        if (in_dead)
        begin
            if (timer_ms >= cfg_dead)
            begin
                in_dead  = 1'b0;
                timer_ms = 0;
                pct      = 0;
            end
            return 1'b0;
        end
        if (cur_dur > 0)
        begin
            q   = (longint'(timer_ms) * PCT_FULL) / cur_dur;
            pct = (q > PCT_FULL) ? PCT_FULL : int'(q);
        end
        if (timer_ms >= cur_dur)
        begin
            r = cur_dur / MS_PER_MIN;
            if (r < 1)
                r = 1;
            if (!test_cycle)
                run_minutes[cur_zone] = (r > MIN_SAT) ? MIN_SAT : r[7:0];
            qpos++;
            if (qpos < qlen)
            begin
                in_wait  = 1'b1;
                timer_ms = 0;
            end
            else
            begin
                run  = 1'b0;
                qlen = 0;
                pct  = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // model: work out the status transaction for one accepted input
    task automatic predict_status(input logic [2:0] f, input logic [3:0] zm,
                                  input logic [7:0] cm, input logic [2:0] tz);
        status_t     s;
        bit          done;
        bit          sel [4];
        int unsigned dur [4];
        logic [7:0]  m;
        logic [7:0]  rep [4];
        done = 1'b0;
        for (int i = 0; i < 4; i++)
            rep[i] = 8'd0;
        case (f)
            FN_TICK:
            begin
                done = tick_step();
                if (done)
                    rep = run_minutes;
            end
            FN_GEN:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    m      = cfg_minutes[8*i +: 8];
                    dur[i] = m * MS_PER_MIN;
                    sel[i] = cfg_enable[i] && (m != 0);
                end
                done = halt_cycle();
                if (done)
                    rep = run_minutes;
                launch(sel, dur, 1'b0);
            end
            FN_CUSTOM:
            begin
                if (cm != 0)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        dur[i] = cm * MS_PER_MIN;
                        sel[i] = zm[i];
                    end
                    done = halt_cycle();
                    if (done)
                        rep = run_minutes;
                    launch(sel, dur, 1'b0);
                end
            end
            FN_TEST:
            begin
                if (cfg_test != 0)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        dur[i] = cfg_test * 1000;
                        sel[i] = tz[2] || (tz == i);
                    end
                    done = halt_cycle();
                    if (done)
                        rep = run_minutes;
                    launch(sel, dur, 1'b1);
                end
            end
            FN_STOP:
            begin
                done = halt_cycle();
                if (done)
                    rep = run_minutes;
            end
            default: ;
        endcase
        s.relay = (run && !in_wait && !in_dead) ? (4'b0001 << cur_zone) : 4'd0;
        s.act   = run;
        s.wt    = run && in_wait;
        s.zn    = run ? cur_zone : 2'd0;
        s.pct   = run ? pct[6:0] : 7'd0;
        s.done  = done;
        s.any   = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            s.mins[i] = (done && i < ZONES) ? rep[i] : 8'd0;
            if (s.mins[i] != 0)
                s.any = 1'b1;
        end
        status_q.push_back(s);
    endtask

    // offer one transaction and hold it until accepted
    task automatic send_item(input logic [2:0] f, input logic [3:0] zm,
                             input logic [7:0] cm, input logic [2:0] tz);
        if (idle_on && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= f;
        zone_mask      <= zm;
        custom_minutes <= cm;
        test_zone      <= tz;
        do
            @(posedge clk);
        while (in_stall);
        predict_status(f, zm, cm, tz);
    endtask

    task automatic tick_n(input int n);
        for (int i = 0; i < n; i++)
            send_item(FN_TICK, 4'd0, 8'd0, 3'd0);
    endtask

    // let every outstanding result drain, then settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RG_ENABLE:  cfg_enable  = value[3:0];
            RG_MINUTES: cfg_minutes = value;
            RG_WAIT:    cfg_wait    = value[23:0];
            RG_DEAD:    cfg_dead    = value[23:0];
            RG_TEST:    cfg_test    = value[11:0];
            default: ;
        endcase
    endtask

    // receiver stalls, result checking and watchdog
    always @(posedge clk)
    begin
        status_t e;
        logic [7:0] got [4];
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        if (out_valid && !out_stall)
        begin
            if (status_q.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                e = status_q.pop_front();
                got = '{minutes_zone0, minutes_zone1, minutes_zone2, minutes_zone3};
                if (relay_mask !== e.relay)
                    report_mismatch("relay_mask", relay_mask, e.relay);
                if (active !== e.act)
                    report_mismatch("active", active, e.act);
                if (waiting !== e.wt)
                    report_mismatch("waiting", waiting, e.wt);
                if (zone !== e.zn)
                    report_mismatch("zone", zone, e.zn);
                if (progress_pct !== e.pct)
                    report_mismatch("progress_pct", progress_pct, e.pct);
                if (cycle_done !== e.done)
                    report_mismatch("cycle_done", cycle_done, e.done);
                if (any_run !== e.any)
                    report_mismatch("any_run", any_run, e.any);
                for (int i = 0; i < 4; i++)
                    if (got[i] !== e.mins[i])
                        report_mismatch($sformatf("minutes_zone%0d", i), got[i], e.mins[i]);
            end
        end
        // long hold-off on request, otherwise random stalls
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_on && ($urandom_range(0, 99) < 16);
    end

    // commands at reset defaults and the ignored or empty starts
    task automatic test_commands();
        send_item(FN_STOP, 4'd0, 8'd0, 3'd0);
        for (int f = FN_STOP + 1; f < FN_CODES; f++)
            send_item(f[2:0], 4'hF, 8'hFF, TZ_ALL);
        send_item(FN_TICK, 4'd0, 8'd0, 3'd0);
        send_item(FN_CUSTOM, 4'hF, 8'd0, 3'd0);
        send_item(FN_CUSTOM, 4'd0, 8'd5, 3'd0);
        send_item(FN_CUSTOM, 4'hF, 8'd255, 3'd0);
        tick_n(3);
        send_item(FN_CUSTOM, 4'b1010, 8'd1, 3'd0);
        tick_n(2);
        send_item(FN_GEN, 4'd0, 8'd0, 3'd0);
        send_item(FN_TEST, 4'd0, 8'd0, 3'd3);
        send_item(FN_TEST, 4'd0, 8'd0, TZ_ALL);
        send_item(FN_TEST, 4'd0, 8'd0, 3'b100);
        tick_n(2);
        send_item(FN_STOP, 4'd0, 8'd0, 3'd0);
        drain();
    endtask

    // registers at their extremes, zero dead time, zero test time
    task automatic test_register_extremes();
        reg_write(RG_ENABLE, 32'hF);
        reg_write(RG_MINUTES, 32'hFFFF_FFFF);
        reg_write(RG_WAIT, 32'h00FF_FFFF);
        reg_write(RG_DEAD, 32'h00FF_FFFF);
        reg_write(RG_TEST, 32'd3600);
        send_item(FN_GEN, 4'd0, 8'd0, 3'd0);
        tick_n(3);
        send_item(FN_TEST, 4'd0, 8'd0, 3'd1);
        tick_n(2);
        send_item(FN_STOP, 4'd0, 8'd0, 3'd0);
        drain();
        reg_write(RG_ENABLE, 32'b1011);
        reg_write(RG_MINUTES, 32'h0102_0300);
        reg_write(RG_DEAD, 32'd0);
        reg_write(RG_WAIT, 32'd0);
        reg_write(RG_TEST, 32'd0);
        send_item(FN_GEN, 4'd0, 8'd0, 3'd0);
        tick_n(5);
        send_item(FN_TEST, 4'd0, 8'd0, TZ_ALL);
        send_item(FN_STOP, 4'd0, 8'd0, 3'd0);
        drain();
    endtask

    // test runs that go to completion through dead time and waits
    task automatic test_zone_completion();
        reg_write(RG_DEAD, 32'd2);
        reg_write(RG_WAIT, 32'd3);
        reg_write(RG_TEST, 32'd1);
        send_item(FN_TEST, 4'd0, 8'd0, TZ_ALL);
        while (run)
            send_item(FN_TICK, 4'd0, 8'd0, 3'd0);
        drain();
        reg_write(RG_DEAD, 32'd0);
        send_item(FN_TEST, 4'd0, 8'd0, 3'd2);
        while (run)
            send_item(FN_TICK, 4'd0, 8'd0, 3'd0);
        drain();
    endtask

    // stop at exactly half a minute into the on period rounds up
    task automatic test_half_minute_stop();
        idle_on = 1'b0;
        send_item(FN_CUSTOM, 4'b0001, 8'd1, 3'd0);
        tick_n(30001);
        send_item(FN_STOP, 4'd0, 8'd0, 3'd0);
        drain();
        idle_on = 1'b1;
    endtask

    // random mix, mostly ticks, with a receiver hold and a sender pause
    task automatic test_random();
        int          r;
        logic [2:0]  f;
        reg_write(RG_DEAD, $urandom_range(0, 3));
        reg_write(RG_WAIT, $urandom_range(0, 3));
        reg_write(RG_TEST, $urandom_range(1, 2));
        reg_write(RG_ENABLE, $urandom_range(0, 15));
        reg_write(RG_MINUTES, $urandom);
        for (int i = 0; i < 1050; i++)
        begin
            if (i == 300)
                hold_asked++;
            if (i == 600)
            begin
                drain();
                reg_write(RG_DEAD, $urandom_range(0, 3));
                reg_write(RG_WAIT, $urandom_range(0, 3));
                reg_write(RG_TEST, $urandom_range(0, 1));
                reg_write(RG_ENABLE, $urandom_range(0, 15));
            end
            r = $urandom_range(0, 99);
            f = (r < 90) ? FN_TICK : 3'($urandom_range(1, FN_CODES - 1));
            send_item(f, 4'($urandom), 8'($urandom), 3'($urandom));
        end
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        func           = FN_TICK;
        zone_mask      = '0;
        custom_minutes = '0;
        test_zone      = '0;
        out_stall      = 1'b0;
        errors         = 0;
        idle_on        = 1'b1;
        hold_asked     = 0;
        hold_seen      = 0;
        hold_left      = 0;
        watchdog       = 0;
        cfg_enable     = 4'd0;
        cfg_minutes    = 32'd0;
        cfg_wait       = 24'd10000;
        cfg_dead       = 24'd500;
        cfg_test       = 12'd10;
        qlen           = 0;
        qpos           = 0;
        run            = 1'b0;
        in_wait        = 1'b0;
        in_dead        = 1'b0;
        test_cycle     = 1'b0;
        cur_zone       = 2'd0;
        cur_dur        = 0;
        timer_ms       = 0;
        pct            = 0;
        for (int i = 0; i < 4; i++)
            run_minutes[i] = 8'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_commands();
        test_register_extremes();
        test_zone_completion();
        test_half_minute_stop();
        test_random();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && status_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/zrs_pkg.sv
src/zrs_ctrl.sv
src/zrs_datapath.sv
src/zone_relay_sequencer.sv
verif/zone_relay_sequencer_tb.sv
